// File: sv/g2ab_pkg.sv
// Shared constants, types and the square root step of the gamma-2 alpha blend core.
package g2ab_pkg;

  // Pipeline depth of the core, counted in register stages.
  localparam int unsigned NSTAGE = 8;

  // Opacity of 1.0 and the fixed-point scale 255 * 256 used by the blend.
  localparam logic [8:0]  ALPHA_ONE  = 9'd256;
  localparam logic [16:0] SCALE      = 17'd65280;
  localparam logic [24:0] SCALE_HALF = 25'd32640;

  // Division by 255: reciprocal floor(2^32 / 255) and the divisor itself.
  localparam logic [24:0] DIV255_M = 25'd16843009;
  localparam logic [26:0] D255     = 27'd255;

  // Widths of the dividend, the quotient and the square root.
  localparam int unsigned DIVIN_W = 27;
  localparam int unsigned DIVQ_W  = 19;
  localparam int unsigned ROOT_W  = 10;
  localparam int unsigned REM_W   = 11;

  // Load enables of a two-stage sub-unit.
  typedef struct packed {
    logic s0;
    logic s1;
  } en2_t;

  // Partial state of the digit-by-digit square root.
  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sq_t;

  // One digit of the square root: bring down two bits and try to subtract.
  function automatic sq_t sq_step(sq_t st, logic [1:0] pair);
    logic [REM_W+1:0] cand;
    logic [REM_W+1:0] trial;
    sq_t              res;
    cand  = {st.rem, pair};
    trial = {1'b0, st.root, 2'b01};
    if (cand >= trial) begin
      res.rem  = REM_W'(cand - trial);
      res.root = {st.root[ROOT_W-2:0], 1'b1};
    end else begin
      res.rem  = cand[REM_W-1:0];
      res.root = {st.root[ROOT_W-2:0], 1'b0};
    end
    return res;
  endfunction

endpackage

// File: sv/gamma2_alpha_blend_pixel_core.sv
// Gamma-2 source-over alpha blend of one ARGB pixel pair per beat.
//
//  channel | direction | ports                         | content
//  --------+-----------+-------------------------------+------------------------------
//  in      | input     | in_tvalid/in_tready/in_tdata   | source and destination pixel
//  out     | output    | out_tvalid/out_tready/out_*    | blended pixel, saturation flag
//  cfg     | input     | cfg_we/cfg_wdata               | global opacity, 256 = 1.0
//
// Eight register stages: products, wide products, linear sum, divide by 255 (two),
// square root (two), round and pack. One beat enters per cycle unless a stall holds the input.
// Each stage holds only while it is full and the stage after it cannot take its beat,
// so a stall at the output fills bubbles before it stops the input.
// rst_n clears the valid bits and sets the opacity to 1.0.
module gamma2_alpha_blend_pixel_core import g2ab_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [31:0] source_pixel, [63:32] dest_pixel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] blended_pixel
  output logic        out_tuser,  // [0] saturated
  input  logic        cfg_we,
  input  logic [8:0]  cfg_wdata
);

  logic [8:0]        const_alpha_r;
  logic [NSTAGE:1]   en;
  logic [NSTAGE:1]   v_r;
  logic [NSTAGE:1]   v_nxt;

  // Opacity register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      const_alpha_r <= ALPHA_ONE;
    end else if (cfg_we) begin
      const_alpha_r <= cfg_wdata;
    end
  end

  // A stage loads when it is empty or its beat moves on.
  always_comb begin
    en[NSTAGE] = !v_r[NSTAGE] || out_tready;
    for (int i = NSTAGE - 1; i >= 1; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
  end

  always_comb begin
    v_nxt[1] = en[1] ? in_tvalid : v_r[1];
    for (int i = 2; i <= NSTAGE; i++) begin
      v_nxt[i] = en[i] ? v_r[i-1] : v_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_tready  = en[1];
  assign out_tvalid = v_r[NSTAGE];

  // Stage 1: scaled source alpha, its complement and the byte squares.
  logic [8:0]  k;
  logic [16:0] a_c;
  logic [7:0]  sa;
  logic [15:0] w1_r;
  logic [15:0] a1_r;
  logic [8:0]  k1_r;
  logic [7:0]  da1_r;
  logic [15:0] dd1_r [3];
  logic [15:0] ss1_r [3];

  assign k   = (const_alpha_r > ALPHA_ONE) ? ALPHA_ONE : const_alpha_r;
  assign sa  = in_tdata[31:24];
  assign a_c = 17'(sa) * 17'(k);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      w1_r  <= 16'(SCALE - a_c);
      a1_r  <= a_c[15:0];
      k1_r  <= k;
      da1_r <= in_tdata[63:56];
      for (int c = 0; c < 3; c++) begin
        dd1_r[c] <= 16'(in_tdata[32+8*c +: 8]) * 16'(in_tdata[32+8*c +: 8]);
        ss1_r[c] <= 16'(in_tdata[8*c +: 8]) * 16'(in_tdata[8*c +: 8]);
      end
    end
  end

  // Stage 2: destination and source products.
  logic [31:0] pw2_r [3];
  logic [24:0] pk2_r [3];
  logic [23:0] pwa2_r;
  logic [15:0] a2_r;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int c = 0; c < 3; c++) begin
        pw2_r[c] <= 32'(w1_r) * 32'(dd1_r[c]);
        pk2_r[c] <= 25'(k1_r) * 25'(ss1_r[c]);
      end
      pwa2_r <= 24'(w1_r) * 24'(da1_r);
      a2_r   <= a1_r;
    end
  end

  // Stage 3: linear sums, pre-shifted so that only a division by 255 remains.
  logic [32:0]        lin   [3];
  logic [24:0]        anum;
  logic [DIVIN_W-1:0] x3_r  [4];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      lin[c] = 33'(pw2_r[c]) + (33'(pk2_r[c]) << 8) - 33'(pk2_r[c]);
    end
    anum = 25'(pwa2_r) + (25'(a2_r) << 8) - 25'(a2_r) + SCALE_HALF;
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int c = 0; c < 3; c++) begin
        x3_r[c] <= lin[c][32:6];
      end
      x3_r[3] <= DIVIN_W'(anum[24:8]);
    end
  end

  // Stages 4 and 5: divide all four lanes by 255.
  en2_t              div_en;
  logic [DIVQ_W-1:0] q5 [4];

  assign div_en = '{s0: en[4], s1: en[5]};

  for (genvar g = 0; g < 4; g++) begin : g_div
    g2ab_div255 u_div (
      .clk (clk),
      .en  (div_en),
      .x   (x3_r[g]),
      .q   (q5[g])
    );
  end

  // Stages 6 and 7: square roots of the colour lanes; alpha is clamped and delayed.
  en2_t              sq_en;
  logic [ROOT_W-1:0] t7 [3];
  logic [7:0]        ao6_r;
  logic              asat6_r;
  logic [7:0]        ao7_r;
  logic              asat7_r;

  assign sq_en = '{s0: en[6], s1: en[7]};

  for (genvar g = 0; g < 3; g++) begin : g_sq
    g2ab_isqrt u_sq (
      .clk (clk),
      .en  (sq_en),
      .y   (q5[g]),
      .t   (t7[g])
    );
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      asat6_r <= |q5[3][DIVQ_W-1:8];
      ao6_r   <= (|q5[3][DIVQ_W-1:8]) ? 8'hFF : q5[3][7:0];
    end
    if (en[7]) begin
      asat7_r <= asat6_r;
      ao7_r   <= ao6_r;
    end
  end

  // Stage 8: round the roots, clamp and pack the output beat.
  logic [8:0]  n     [3];
  logic [2:0]  csat;
  logic [23:0] rgb;
  logic [31:0] out_data_r;
  logic        out_sat_r;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      n[c]             = 9'((11'(t7[c]) + 11'd1) >> 1);
      csat[c]          = n[c][8];
      rgb[8*c +: 8]    = n[c][8] ? 8'hFF : n[c][7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[NSTAGE]) begin
      out_data_r <= {ao7_r, rgb};
      out_sat_r  <= asat7_r | (|csat);
    end
  end

  assign out_tdata = out_data_r;
  assign out_tuser = out_sat_r;

endmodule

// File: sv/g2ab_div255.sv
// Two-stage pipelined divider by the constant 255 using a reciprocal multiply.
module g2ab_div255 import g2ab_pkg::*; (
  input  logic              clk,
  input  en2_t              en,
  input  logic [DIVIN_W-1:0] x,
  output logic [DIVQ_W-1:0]  q
);

  logic [51:0]         prod;
  logic [DIVIN_W-1:0]  x_r;
  logic [DIVQ_W-1:0]   qe_r;
  logic [DIVIN_W-1:0]  r;
  logic [DIVQ_W-1:0]   q_r;

  // First stage: the estimate is the true quotient or one below it.
  assign prod = 52'(x) * 52'(DIV255_M);

  always_ff @(posedge clk) begin
    if (en.s0) begin
      x_r  <= x;
      qe_r <= prod[50:32];
    end
  end

  // Second stage: the remainder tells whether the estimate is one short.
  assign r = x_r - ((DIVIN_W'(qe_r) << 8) - DIVIN_W'(qe_r));

  always_ff @(posedge clk) begin
    if (en.s1) begin
      q_r <= qe_r + DIVQ_W'(r >= D255);
    end
  end

  assign q = q_r;

endmodule

// File: sv/g2ab_isqrt.sv
// Two-stage pipelined integer square root of a 19-bit value, five digits per stage.
module g2ab_isqrt import g2ab_pkg::*; (
  input  logic              clk,
  input  en2_t              en,
  input  logic [DIVQ_W-1:0] y,
  output logic [ROOT_W-1:0] t
);

  logic [19:0]       y20;
  sq_t               st_a;
  sq_t               st_b;
  sq_t               st_a_r;
  logic [9:0]        ylo_r;
  logic [ROOT_W-1:0] t_r;

  assign y20 = {1'b0, y};

  // Upper five digits from the top ten bits.
  always_comb begin
    st_a = '0;
    for (int i = 0; i < 5; i++) begin
      st_a = sq_step(st_a, y20[19-2*i -: 2]);
    end
  end

  always_ff @(posedge clk) begin
    if (en.s0) begin
      st_a_r <= st_a;
      ylo_r  <= y20[9:0];
    end
  end

  // Lower five digits from the remaining ten bits.
  always_comb begin
    st_b = st_a_r;
    for (int i = 0; i < 5; i++) begin
      st_b = sq_step(st_b, ylo_r[9-2*i -: 2]);
    end
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      t_r <= st_b.root;
    end
  end

  assign t = t_r;

endmodule

// File: sv/g2ab_check.sv
// Port-level checker for the gamma-2 alpha blend core, bound to the top level.
module g2ab_check (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tuser
);

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output beat valid straight after reset");

  // A clamped beat always carries at least one byte at full scale.
  a_sat_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |->
      (out_tdata[31:24] == 8'hFF || out_tdata[23:16] == 8'hFF ||
       out_tdata[15:8] == 8'hFF || out_tdata[7:0] == 8'hFF))
    else $error("saturation flag without a clamped byte");

  // With the output side ready the pipeline never pushes back on the input.
  a_no_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("input stalled while output ready");

  // A beat waiting at the output holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=>
      (out_tvalid && $stable(out_tdata) && $stable(out_tuser)))
    else $error("stalled output beat changed");

endmodule

bind gamma2_alpha_blend_pixel_core g2ab_check u_g2ab_check (.*);
